/* rtl/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, constants and helpers for the chacha stream cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

   localparam int ROUND_COUNT   = 20;
   localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
   localparam int QR_TOTAL      = DOUBLE_ROUNDS * 8;
   localparam int STEP_W        = $clog2(QR_TOTAL);

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int POS_W       = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [31:0] SIGMA_0      = 32'h6170_7865;
   localparam logic [31:0] SIGMA_1_LONG = 32'h3320_646e;
   localparam logic [31:0] SIGMA_2_LONG = 32'h7962_2d32;
   localparam logic [31:0] SIGMA_1_SHRT = 32'h3120_646e;
   localparam logic [31:0] SIGMA_2_SHRT = 32'h7962_2d36;
   localparam logic [31:0] SIGMA_3      = 32'h6b20_6574;

   typedef logic [WORD_W-1:0]              word_type;
   typedef word_type [BLOCK_WORDS-1:0]     block_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_0_7     = 3'd0,
      CSR_KEY_8_15    = 3'd1,
      CSR_KEY_16_23   = 3'd2,
      CSR_KEY_24_31   = 3'd3,
      CSR_LONG_KEY    = 3'd4,
      CSR_NONCE       = 3'd5,
      CSR_START_COUNT = 3'd6
   } csr_index_type;

   // input state of one block: constants, key, counter, nonce
   function automatic block_type build_init(
      input logic [63:0] key_0,
      input logic [63:0] key_1,
      input logic [63:0] key_2,
      input logic [63:0] key_3,
      input logic        long_mode,
      input logic [63:0] counter,
      input logic [63:0] nonce
   );
      block_type s;
      s[0]  = SIGMA_0;
      s[1]  = long_mode ? SIGMA_1_LONG : SIGMA_1_SHRT;
      s[2]  = long_mode ? SIGMA_2_LONG : SIGMA_2_SHRT;
      s[3]  = SIGMA_3;
      s[4]  = key_0[31:0];
      s[5]  = key_0[63:32];
      s[6]  = key_1[31:0];
      s[7]  = key_1[63:32];
      s[8]  = long_mode ? key_2[31:0]  : key_0[31:0];
      s[9]  = long_mode ? key_2[63:32] : key_0[63:32];
      s[10] = long_mode ? key_3[31:0]  : key_1[31:0];
      s[11] = long_mode ? key_3[63:32] : key_1[63:32];
      s[12] = counter[31:0];
      s[13] = counter[63:32];
      s[14] = nonce[31:0];
      s[15] = nonce[63:32];
      return s;
   endfunction

endpackage

`default_nettype wire

/* rtl/ccs_if.sv */
// ----------------------------------------------------------------------------
// ccs_if
// Valid/ready channels for message bytes in and combined bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       message_end;

   modport source (output valid, output data_byte, output message_end, input ready);
   modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

/* rtl/ccs_qround.sv */
// ----------------------------------------------------------------------------
// ccs_qround
// One chacha quarter round on four words, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_qround
   import ccs_pkg::*;
(
   input  word_type a_in,
   input  word_type b_in,
   input  word_type c_in,
   input  word_type d_in,
   output word_type a_out,
   output word_type b_out,
   output word_type c_out,
   output word_type d_out
);

   word_type a1, b1, c1, d1;
   word_type a2, b2, c2, d2;
   word_type dx1, bx1, dx2, bx2;

   always_comb begin
      a1  = a_in + b_in;
      dx1 = d_in ^ a1;
      d1  = {dx1[15:0], dx1[31:16]};
      c1  = c_in + d1;
      bx1 = b_in ^ c1;
      b1  = {bx1[19:0], bx1[31:20]};
      a2  = a1 + b1;
      dx2 = d1 ^ a2;
      d2  = {dx2[23:0], dx2[31:24]};
      c2  = c1 + d2;
      bx2 = b1 ^ c2;
      b2  = {bx2[24:0], bx2[31:25]};
   end

   assign a_out = a2;
   assign b_out = b2;
   assign c_out = c2;
   assign d_out = d2;

endmodule

`default_nettype wire

/* rtl/ccs_core.sv */
// ----------------------------------------------------------------------------
// ccs_core
// Block function: one shared quarter-round unit stepped by a small
// sequencer, then the feed-forward add of the input state.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_core
   import ccs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  block_type init_words,
   output logic      done,
   output block_type words
);

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_FINISH
   } core_state_type;

   core_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               done_ff, done_in;
   block_type          work_ff, work_in;

   logic      diag;
   word_type  qa, qb, qc, qd;
   word_type  ra, rb, rc, rd;
   block_type placed;

   // rows rotate left by one word after each step, so the unit always reads
   // fixed positions: the column or the main diagonal
   assign diag = step_ff[2];
   assign qa   = work_ff[0];
   assign qb   = diag ? work_ff[5]  : work_ff[4];
   assign qc   = diag ? work_ff[10] : work_ff[8];
   assign qd   = diag ? work_ff[15] : work_ff[12];

   ccs_qround u_qround (
      .a_in  (qa),
      .b_in  (qb),
      .c_in  (qc),
      .d_in  (qd),
      .a_out (ra),
      .b_out (rb),
      .c_out (rc),
      .d_out (rd)
   );

   always_comb begin
      placed    = work_ff;
      placed[0] = ra;
      if (diag) begin
         placed[5]  = rb;
         placed[10] = rc;
         placed[15] = rd;
      end else begin
         placed[4]  = rb;
         placed[8]  = rc;
         placed[12] = rd;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      work_in  = work_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (start) begin
               work_in  = init_words;
               step_in  = '0;
               state_in = CORE_ROUND;
            end
         end
         CORE_ROUND: begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  work_in[r*4 + c] = placed[r*4 + ((c + 1) % 4)];
               end
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QR_TOTAL - 1)) begin
               state_in = CORE_FINISH;
            end
         end
         CORE_FINISH: begin
            for (int i = 0; i < BLOCK_WORDS; i++) begin
               work_in[i] = work_ff[i] + init_words[i];
            end
            done_in  = 1'b1;
            state_in = CORE_IDLE;
         end
         default: begin
            state_in = CORE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      work_ff <= work_in;
   end

   assign done  = done_ff;
   assign words = work_ff;

endmodule

`default_nettype wire

/* rtl/chacha_stream_cipher.sv */
// ----------------------------------------------------------------------------
// chacha_stream_cipher
// Original chacha with 64-bit block counter and 64-bit nonce, one byte a word.
// ----------------------------------------------------------------------------
// Each accepted byte comes back XORed with the next keystream byte. Bytes in
// the middle of a block go straight to the output register, so a result
// appears the cycle after acceptance and bytes stream at one per cycle while
// the receiver keeps taking them. The first byte of every 64-byte block waits
// for a new keystream block. The input state is loaded on the accepting edge,
// then one quarter-round unit is stepped 4 * ROUND_COUNT times, followed by
// one feed-forward add, the handover of the block and the output register;
// no new byte is taken until that first byte reaches the output register. A
// byte with message_end set drops the rest of the block. Writing the start
// counter register loads the block counter and restarts at a block boundary;
// key, mode and nonce writes take effect at the next block. Configuration
// must be written only while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha_stream_cipher
   import ccs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ccs_req_if.sink                req_if,
   ccs_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_GEN,
      TOP_EMIT
   } top_state_type;

   logic [63:0] key_0_ff, key_1_ff, key_2_ff, key_3_ff, nonce_ff;
   logic        long_mode_ff;

   top_state_type    state_ff;
   logic [63:0]      counter_ff;
   logic [POS_W-1:0] pos_ff;
   logic [7:0]       data_ff;
   logic             last_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   logic      slot_free;
   logic      accept;
   logic      core_start;
   logic      core_done;
   block_type init_words;
   block_type ks_words;
   word_type  ks_word;
   logic [7:0] ks_byte;
   logic      emit;
   logic [7:0] emit_data;
   logic      emit_last;

   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == TOP_IDLE) && slot_free;
   assign accept        = req_if.valid && req_if.ready;
   assign core_start    = accept && (pos_ff == '0);

   assign init_words = build_init(key_0_ff, key_1_ff, key_2_ff, key_3_ff,
                                  long_mode_ff, counter_ff, nonce_ff);

   ccs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (core_start),
      .init_words (init_words),
      .done       (core_done),
      .words      (ks_words)
   );

   // keystream byte i is byte i mod 4 of word i / 4, little-endian
   assign ks_word = ks_words[pos_ff[5:2]];
   assign ks_byte = ks_word[{pos_ff[1:0], 3'b000} +: 8];

   assign emit = (accept && (pos_ff != '0)) || ((state_ff == TOP_EMIT) && slot_free);
   assign emit_data = (state_ff == TOP_EMIT) ? data_ff : req_if.data_byte;
   assign emit_last = (state_ff == TOP_EMIT) ? last_ff : req_if.message_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_ff     <= '0;
         key_1_ff     <= '0;
         key_2_ff     <= '0;
         key_3_ff     <= '0;
         long_mode_ff <= 1'b1;
         nonce_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_0_7:   key_0_ff     <= csr_wr_data;
            CSR_KEY_8_15:  key_1_ff     <= csr_wr_data;
            CSR_KEY_16_23: key_2_ff     <= csr_wr_data;
            CSR_KEY_24_31: key_3_ff     <= csr_wr_data;
            CSR_LONG_KEY:  long_mode_ff <= csr_wr_data[0];
            CSR_NONCE:     nonce_ff     <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         counter_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            TOP_IDLE: begin
               if (core_start) begin
                  state_ff <= TOP_GEN;
               end
            end
            TOP_GEN: begin
               if (core_done) begin
                  state_ff <= TOP_EMIT;
               end
            end
            TOP_EMIT: begin
               if (slot_free) begin
                  state_ff <= TOP_IDLE;
               end
            end
            default: begin
               state_ff <= TOP_IDLE;
            end
         endcase
         if (csr_wr_en && (csr_index == CSR_START_COUNT)) begin
            counter_ff <= csr_wr_data;
            pos_ff     <= '0;
         end else begin
            if (core_done) begin
               counter_ff <= counter_ff + 64'd1;
            end
            if (emit) begin
               pos_ff <= emit_last ? '0 : pos_ff + POS_W'(1);
            end
         end
      end
      if (core_start) begin
         data_ff <= req_if.data_byte;
         last_ff <= req_if.message_end;
      end
      if (emit) begin
         rsp_byte_ff <= emit_data ^ ks_byte;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_byte = rsp_byte_ff;
   assign rsp_if.out_last = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/ccs_checker.sv */
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks on the cipher's byte channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] out_byte,
   input wire       out_last
);

   // output register comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a stalled result blocks new input words
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result stalled");

   // each accepted word either shows a result next or keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid || !req_ready))
      else $error("accepted word produced neither result nor busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_byte) && $stable(out_last)))
      else $error("stalled result changed");

endmodule

bind chacha_stream_cipher ccs_checker u_ccs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .out_byte  (rsp_if.out_byte),
   .out_last  (rsp_if.out_last)
);

`default_nettype wire

/* verif/chacha_stream_cipher_tb.sv */
// ----------------------------------------------------------------------------
// chacha_stream_cipher_tb
// Streams message bytes through the cipher under changing key, nonce, mode
// and counter settings. Every returned word is checked against an in-bench
// keystream model, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module chacha_stream_cipher_tb;
   import ccs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int unsigned ITEM_GOAL = 1750;
   localparam int unsigned LONG_HOLD_CYCLES = 600;
   localparam int unsigned DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } plain_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   ccs_req_if req_if();
   ccs_rsp_if rsp_if();

   chacha_stream_cipher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // model of the cipher state
   logic [63:0] ks_key [4];
   logic        ks_long_mode;
   logic [63:0] ks_nonce;
   logic [63:0] ks_counter;
   logic [5:0]  ks_pos;
   block_type   ks_block;

   plain_word_type  plain_queue [$];
   cipher_word_type cipher_due [$];

   int unsigned error_count   = 0;
   int unsigned items_queued  = 0;
   int unsigned words_checked = 0;
   int unsigned blocks_made   = 0;
   int unsigned phase_count   = 0;

   int unsigned gap_max = 0;
   int unsigned burst_left, gap_left;
   plain_word_type next_plain;

   logic        long_hold_armed = 1'b0;
   logic        long_hold_done  = 1'b0;
   int unsigned hold_left  = 0;
   int unsigned ready_mode = 0;
   int unsigned mode_left  = 0;
   logic [15:0] stall_mask = '1;
   logic        ready_next;

   cipher_word_type got_word, exp_word;

   initial forever #2 clock = ~clock;

   function automatic word_type rotl(word_type v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic block_type quarter_round(block_type s, int a, int b, int c, int d);
      s[a] = s[a] + s[b];  s[d] = rotl(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d];  s[b] = rotl(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b];  s[d] = rotl(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d];  s[b] = rotl(s[b] ^ s[c], 7);
      return s;
   endfunction

   function automatic void refill_keystream();
      block_type   init_state, work;
      logic [63:0] key_sel;
      int          r, k;
      init_state[0] = SIGMA_0;
      init_state[1] = ks_long_mode ? SIGMA_1_LONG : SIGMA_1_SHRT;
      init_state[2] = ks_long_mode ? SIGMA_2_LONG : SIGMA_2_SHRT;
      init_state[3] = SIGMA_3;
      // short key mode repeats the first 16 key bytes
      for (k = 0; k < 4; k++) begin
         key_sel = (k < 2 || ks_long_mode) ? ks_key[k] : ks_key[k - 2];
         init_state[4 + 2 * k] = key_sel[31:0];
         init_state[5 + 2 * k] = key_sel[63:32];
      end
      init_state[12] = ks_counter[31:0];
      init_state[13] = ks_counter[63:32];
      init_state[14] = ks_nonce[31:0];
      init_state[15] = ks_nonce[63:32];
      work = init_state;
      for (r = 0; r < ROUND_COUNT; r += 2) begin
         work = quarter_round(work, 0, 4, 8, 12);
         work = quarter_round(work, 1, 5, 9, 13);
         work = quarter_round(work, 2, 6, 10, 14);
         work = quarter_round(work, 3, 7, 11, 15);
         work = quarter_round(work, 0, 5, 10, 15);
         work = quarter_round(work, 1, 6, 11, 12);
         work = quarter_round(work, 2, 7, 8, 13);
         work = quarter_round(work, 3, 4, 9, 14);
      end
      for (k = 0; k < BLOCK_WORDS; k++) ks_block[k] = work[k] + init_state[k];
      ks_counter = ks_counter + 64'd1;
      blocks_made++;
   endfunction

   function automatic cipher_word_type xor_keystream_byte(plain_word_type item);
      cipher_word_type res;
      word_type        w;
      if (ks_pos == 6'd0) refill_keystream();
      w = ks_block[ks_pos[5:2]];
      res.out_byte = item.data_byte ^ w[{ks_pos[1:0], 3'b000} +: 8];
      res.out_last = item.message_end;
      ks_pos = item.message_end ? 6'd0 : ks_pos + 6'd1;
      return res;
   endfunction

   function automatic void push_plain(logic [7:0] data, logic last);
      plain_word_type item;
      item.data_byte   = data;
      item.message_end = last;
      plain_queue.push_back(item);
      items_queued++;
   endfunction

   function automatic void queue_message(int unsigned len, bit ends);
      int unsigned i;
      for (i = 0; i < len; i++)
         push_plain(8'($urandom_range(0, 255)), ends && (i == len - 1));
   endfunction

   function automatic logic [63:0] pick_value64();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_counter();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'h0000_0000_ffff_ffff;
         3: return {$urandom, 32'hffff_fffe};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_KEY_0_7:   ks_key[0] = value;
         CSR_KEY_8_15:  ks_key[1] = value;
         CSR_KEY_16_23: ks_key[2] = value;
         CSR_KEY_24_31: ks_key[3] = value;
         CSR_LONG_KEY:  ks_long_mode = value[0];
         CSR_NONCE:     ks_nonce = value;
         CSR_START_COUNT: begin
            ks_counter = value;
            ks_pos     = 6'd0;
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (plain_queue.size() != 0 || req_if.valid || cipher_due.size() != 0);
   endtask

   // sender: bursts of words with random gaps, valid held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.data_byte   <= '0;
         req_if.message_end <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0 || plain_queue.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            next_plain = plain_queue.pop_front();
            req_if.valid       <= 1'b1;
            req_if.data_byte   <= next_plain.data_byte;
            req_if.message_end <= next_plain.message_end;
            if (burst_left != 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end
      end
   end

   // receiver: stall pattern is redrawn when its random run ends, one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (long_hold_armed && !long_hold_done) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 300);
            stall_mask = 16'($urandom);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (ready_mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = ($urandom_range(0, 3) == 0);
               default: begin
                  ready_next = stall_mask[0];
                  stall_mask = {stall_mask[0], stall_mask[15:1]};
               end
            endcase
         end
         rsp_if.ready <= ready_next;
      end
   end

   // monitor: predict on input acceptance, then check the output word
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            cipher_due.push_back(xor_keystream_byte({req_if.data_byte, req_if.message_end}));
         if (rsp_if.valid && rsp_if.ready) begin
            got_word.out_byte = rsp_if.out_byte;
            got_word.out_last = rsp_if.out_last;
            words_checked++;
            if (cipher_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected word byte %h last %b", $realtime,
                           got_word.out_byte, got_word.out_last);
            end else begin
               exp_word = cipher_due.pop_front();
               if (got_word.out_byte !== exp_word.out_byte ||
                   got_word.out_last !== exp_word.out_last) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: word %0d byte exp %h got %h, last exp %b got %b",
                              $realtime, words_checked, exp_word.out_byte,
                              got_word.out_byte, exp_word.out_last, got_word.out_last);
               end
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("chacha_stream_cipher_tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned target, queued_here, len, plan;
      for (int k = 0; k < 4; k++) ks_key[k] = '0;
      ks_long_mode = 1'b1;
      ks_nonce     = '0;
      ks_counter   = '0;
      ks_pos       = '0;
      ks_block     = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes, ends mid-block, a one-byte message
      phase_count++;
      push_plain(8'h00, 1'b0);
      push_plain(8'hff, 1'b0);
      push_plain(8'h01, 1'b0);
      push_plain(8'h80, 1'b0);
      push_plain(8'h7f, 1'b1);
      push_plain(8'haa, 1'b1);
      push_plain(8'h55, 1'b0);
      push_plain(8'h00, 1'b0);
      wait_drained();

      // nonce changed with a block open: old keystream runs out first
      phase_count++;
      write_csr(CSR_NONCE, '1);
      push_plain(8'hff, 1'b0);
      push_plain(8'h00, 1'b1);
      push_plain(8'hc3, 1'b1);
      wait_drained();

      // short key mode, ignored index, counter wrap to zero
      phase_count++;
      write_csr(CSR_UNUSED_INDEX, {$urandom, $urandom});
      write_csr(CSR_KEY_0_7, '1);
      write_csr(CSR_KEY_8_15, '1);
      write_csr(CSR_KEY_16_23, '1);
      write_csr(CSR_KEY_24_31, '1);
      write_csr(CSR_LONG_KEY, 64'hffff_ffff_ffff_fffe);
      write_csr(CSR_START_COUNT, '1);
      push_plain(8'h00, 1'b1);
      push_plain(8'hff, 1'b1);
      wait_drained();

      // carry from the low counter word into the high one
      phase_count++;
      write_csr(CSR_START_COUNT, 64'h0000_0000_ffff_ffff);
      push_plain(8'h5a, 1'b1);
      push_plain(8'ha5, 1'b1);
      wait_drained();

      phase_count++;
      write_csr(CSR_LONG_KEY, 64'h0000_0000_0000_0001);
      push_plain(8'h00, 1'b1);
      wait_drained();

      while (items_queued < ITEM_GOAL) begin
         phase_count++;
         if (phase_count == 6 || $urandom_range(0, 1)) write_csr(CSR_KEY_0_7, pick_value64());
         if (phase_count == 6 || $urandom_range(0, 1)) write_csr(CSR_KEY_8_15, pick_value64());
         if (phase_count == 6 || $urandom_range(0, 1)) write_csr(CSR_KEY_16_23, pick_value64());
         if (phase_count == 6 || $urandom_range(0, 1)) write_csr(CSR_KEY_24_31, pick_value64());
         if ($urandom_range(0, 1)) write_csr(CSR_LONG_KEY, {$urandom, $urandom});
         if ($urandom_range(0, 1)) write_csr(CSR_NONCE, pick_value64());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_START_COUNT, pick_counter());
         if ($urandom_range(0, 5) == 0) write_csr(CSR_UNUSED_INDEX, {$urandom, $urandom});

         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         plan    = $urandom_range(0, 4);
         if (plan == 0) begin
            // one long message across several blocks
            queue_message($urandom_range(130, 200), 1'($urandom_range(0, 1)));
         end else begin
            target      = $urandom_range(100, 200);
            queued_here = 0;
            while (queued_here < target) begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 70)
                                                 : $urandom_range(1, 16);
               queue_message(len, 1'b1);
               queued_here += len;
            end
            // leave a block open so the next settings land mid-block
            if ($urandom_range(0, 2) == 0) queue_message($urandom_range(1, 30), 1'b0);
         end
         if (phase_count == 8) begin
            gap_max         = 0;
            long_hold_armed = 1'b1;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d bytes over %0d settings, %0d keystream blocks",
               items_queued, phase_count, blocks_made);
      $display("%0d output words checked, %0d mismatches", words_checked, error_count);
      if (error_count == 0)
         $display("chacha_stream_cipher_tb: done, clean");
      else
         $display("chacha_stream_cipher_tb: done, errors");
      $finish;
   end

endmodule

/* files.f */
rtl/ccs_pkg.sv
rtl/ccs_if.sv
rtl/ccs_qround.sv
rtl/ccs_core.sv
rtl/chacha_stream_cipher.sv
rtl/ccs_checker.sv
verif/chacha_stream_cipher_tb.sv
